// ===== hdl/wildcard_rule_classifier_core_assert.svh =====
// Assertion macros shared by the classifier RTL.
`ifndef WILDCARD_RULE_CLASSIFIER_CORE_ASSERT_SVH
`define WILDCARD_RULE_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define WRC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/wrc_pkg.sv =====
`timescale 1ns / 1ps

package wrc_pkg;

   localparam int KEY_W        = 8;
   localparam int PORT_W       = 8;
   localparam int SLOT_W       = 4;
   localparam int CFG_W        = 5;
   localparam int RULE_DEPTH_D = 16;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0]  key_a;
      logic [KEY_W-1:0]  key_b;
      logic              wild_a;
      logic              wild_b;
      logic [PORT_W-1:0] port;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic write_rule;   // store the request as a rule
      logic load_lookup;  // latch key and bound, restart the scan
      logic scan;         // issue reads and compare
      logic emit_drop;    // deliver a drop without scanning
      logic emit_scan;    // deliver the outcome of the scan
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic limit_zero;   // nothing to search
      logic found;        // entry under compare matches
      logic exhausted;    // entry under compare is the last in range
   } sts_type;

endpackage

// ===== hdl/wrc_ram.sv =====
`timescale 1ns / 1ps

module wrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/wrc_ctrl.sv =====
`timescale 1ns / 1ps
`include "wildcard_rule_classifier_core_assert.svh"

module wrc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             command,
   input  wrc_pkg::sts_type sts,
   output wrc_pkg::cmd_type cmd,
   output logic             busy
);

   wrc_pkg::state_type state_ff;
   wrc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      unique case (state_ff)
         wrc_pkg::ST_IDLE: begin
            if (start) begin
               if (command == wrc_pkg::CMD_WRITE) begin
                  cmd.write_rule = 1'b1;
               end else if (sts.limit_zero) begin
                  cmd.emit_drop = 1'b1;
               end else begin
                  cmd.load_lookup = 1'b1;
                  state_in        = wrc_pkg::ST_SCAN;
               end
            end
         end
         wrc_pkg::ST_SCAN: begin
            busy     = 1'b1;
            cmd.scan = 1'b1;
            if (sts.found || sts.exhausted) begin
               cmd.emit_scan = 1'b1;
               state_in      = wrc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wrc_pkg::ST_IDLE;
         end
      endcase
   end

   `WRC_ASSERT_NEXT(a_scan_ends, (state_ff == wrc_pkg::ST_SCAN) && (sts.found || sts.exhausted), state_ff == wrc_pkg::ST_IDLE, "scan did not end on a decision")

endmodule

// ===== hdl/wrc_dpath.sv =====
`timescale 1ns / 1ps

module wrc_dpath #(
   parameter int RULE_DEPTH = wrc_pkg::RULE_DEPTH_D
) (
   input  logic                        clock,
   input  logic                        reset,
   input  wrc_pkg::cmd_type            cmd,
   output wrc_pkg::sts_type            sts,
   input  logic [wrc_pkg::SLOT_W-1:0]  rule_slot,
   input  logic [wrc_pkg::KEY_W-1:0]   first_key,
   input  logic [wrc_pkg::KEY_W-1:0]   second_key,
   input  logic                        first_wild,
   input  logic                        second_wild,
   input  logic [wrc_pkg::PORT_W-1:0]  rule_port,
   input  logic                        cfg_wr,
   input  logic [wrc_pkg::CFG_W-1:0]   cfg_data,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [wrc_pkg::PORT_W-1:0]  rsp_port,
   output logic [wrc_pkg::SLOT_W-1:0]  rsp_rule_number
);

   localparam int AW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int CW = wrc_pkg::CFG_W;

   logic [CW-1:0]               rules_in_use_ff;
   logic [CW-1:0]               limit;
   logic [CW-1:0]               limit_ff;
   logic [wrc_pkg::KEY_W-1:0]   key_a_ff;
   logic [wrc_pkg::KEY_W-1:0]   key_b_ff;
   logic [CW-1:0]               idx_ff;
   logic [CW-1:0]               rd_idx_ff;
   logic                        rd_vld_ff;
   logic                        issue;
   logic                        slot_ok;
   logic                        match;
   wrc_pkg::rule_type           wr_rule;
   wrc_pkg::rule_type           rd_rule;
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic [wrc_pkg::PORT_W-1:0]  rsp_port_ff;
   logic [wrc_pkg::SLOT_W-1:0]  rsp_rule_number_ff;

   // bound the search by the table depth
   assign limit   = (32'(rules_in_use_ff) > 32'(RULE_DEPTH)) ? CW'(RULE_DEPTH)
                                                              : rules_in_use_ff;
   assign slot_ok = 32'(rule_slot) < 32'(RULE_DEPTH);
   assign issue   = cmd.scan && (idx_ff < limit_ff);

   assign wr_rule = '{key_a: first_key, key_b: second_key, wild_a: first_wild,
                      wild_b: second_wild, port: rule_port};

   wrc_ram #(
      .WIDTH (wrc_pkg::RULE_W),
      .DEPTH (RULE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write_rule && slot_ok),
      .wr_addr (AW'(rule_slot)),
      .wr_data (wr_rule),
      .rd_en   (issue),
      .rd_addr (AW'(idx_ff)),
      .rd_data (rd_rule)
   );

   assign match = (rd_rule.wild_a || (rd_rule.key_a == key_a_ff)) &&
                  (rd_rule.wild_b || (rd_rule.key_b == key_b_ff));

   assign sts.limit_zero = (limit == '0);
   assign sts.found      = rd_vld_ff && match;
   assign sts.exhausted  = rd_vld_ff && ({1'b0, rd_idx_ff} + 1'b1 == {1'b0, limit_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         rules_in_use_ff <= '0;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (cfg_wr) begin
            rules_in_use_ff <= cfg_data;
         end
         rd_vld_ff    <= issue;
         rsp_valid_ff <= cmd.emit_drop || cmd.emit_scan;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_lookup) begin
         key_a_ff <= first_key;
         key_b_ff <= second_key;
         limit_ff <= limit;
         idx_ff   <= '0;
      end else if (issue) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (issue) begin
         rd_idx_ff <= idx_ff;
      end
      if (cmd.emit_scan && sts.found) begin
         rsp_hit_ff         <= 1'b1;
         rsp_port_ff        <= rd_rule.port;
         rsp_rule_number_ff <= rd_idx_ff[wrc_pkg::SLOT_W-1:0];
      end else if (cmd.emit_drop || cmd.emit_scan) begin
         rsp_hit_ff         <= 1'b0;
         rsp_port_ff        <= '0;
         rsp_rule_number_ff <= '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_port        = rsp_port_ff;
   assign rsp_rule_number = rsp_rule_number_ff;

endmodule

// ===== hdl/wildcard_rule_classifier_core.sv =====
`timescale 1ns / 1ps
`include "wildcard_rule_classifier_core_assert.svh"

// First-match wildcard rule classifier. An item is taken when start is high
// and busy is low. A write item (command 0) stores one rule in the slot it
// names in the same cycle and gives no result; busy stays low, so the next
// item may follow at once. A lookup item (command 1) scans slots 0 up to the
// lesser of rules_in_use and RULE_DEPTH, minus one, in order, one stored rule
// per cycle through the single read port of the rule RAM; busy stays high
// while the scan runs, and the result strobe rsp_valid comes in the cycle
// after the deciding compare. A lookup with nothing to search returns a
// drop in the next cycle without going busy. The result is on the rsp_ ports
// for exactly one cycle and cannot be held off: capture it when rsp_valid is
// high. On a drop (rsp_hit low), port and rule_number are zero. rules_in_use
// is written through the csr_ channel, which is ready whenever the block is
// not scanning; write it only while no lookup is outstanding. Slots are never
// cleared: search only slots already written.
module wildcard_rule_classifier_core #(
   parameter int RULE_DEPTH = wrc_pkg::RULE_DEPTH_D
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_command,
   input  logic [wrc_pkg::SLOT_W-1:0]  req_rule_slot,
   input  logic [wrc_pkg::KEY_W-1:0]   req_first_key,
   input  logic [wrc_pkg::KEY_W-1:0]   req_second_key,
   input  logic                        req_first_wild,
   input  logic                        req_second_wild,
   input  logic [wrc_pkg::PORT_W-1:0]  req_rule_port,
   // result channel
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [wrc_pkg::PORT_W-1:0]  rsp_port,
   output logic [wrc_pkg::SLOT_W-1:0]  rsp_rule_number,
   // configuration
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [wrc_pkg::CFG_W-1:0]   csr_rules_in_use
);

   wrc_pkg::cmd_type cmd;
   wrc_pkg::sts_type sts;

   // sequencer: accept items, run the scan, time the result strobe
   wrc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .sts     (sts),
      .cmd     (cmd),
      .busy    (busy)
   );

   // rule table, compare unit and result register
   wrc_dpath #(
      .RULE_DEPTH (RULE_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .rule_slot       (req_rule_slot),
      .first_key       (req_first_key),
      .second_key      (req_second_key),
      .first_wild      (req_first_wild),
      .second_wild     (req_second_wild),
      .rule_port       (req_rule_port),
      .cfg_wr          (csr_valid && csr_ready),
      .cfg_data        (csr_rules_in_use),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_port        (rsp_port),
      .rsp_rule_number (rsp_rule_number)
   );

   // hold the register still while a scan reads its bound
   assign csr_ready = !busy;

   // a result always lands once the scan has released the request side
   `WRC_ASSERT_NOW(a_rsp_when_free, rsp_valid, !busy, "result strobe while still scanning")
   // a drop carries zero port and slot
   `WRC_ASSERT_NOW(a_drop_zero, rsp_valid && !rsp_hit, (rsp_port == '0) && (rsp_rule_number == '0), "drop with non-zero fields")
   // a lookup that goes busy ends the busy stretch with a result
   `WRC_ASSERT_NEXT(a_busy_fall_rsp, busy && !cmd.emit_scan && !sts.found && !sts.exhausted, busy, "scan released without a decision")

endmodule
